// ----- design/fser_pkg.sv -----
// ----------------------------------------------------------------------------
// fser_pkg: shared constants and types of the event ring serialiser
// sizes of the record ring, name handling, word codes and the records that
// pass between the front end, the command queue and the back end
// ----------------------------------------------------------------------------
package fser_pkg;

   // ring and name sizing
   localparam int QUEUE_DEPTH    = 32;
   localparam int NAME_BYTES     = 16;
   localparam int NAME_CHARS     = NAME_BYTES - 1;
   localparam int NAME_WORDS_MAX = (NAME_BYTES + 3) / 4;
   localparam int NAME_SLOTS     = NAME_WORDS_MAX * 4;
   localparam int NAME_BITS      = NAME_SLOTS * 8;
   localparam int HDR_WORDS      = 4;

   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int WCNT_W = $clog2(NAME_WORDS_MAX + 1);
   localparam int WIDX_W = $clog2(HDR_WORDS + NAME_WORDS_MAX);

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // fixed field widths
   localparam int DATA_W     = 32;
   localparam int RAW_NAME_W = 64;
   localparam int CAP_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int BYTES_W    = 6;
   localparam int PEND_W     = 6;

   localparam int REQ_TDATA_W = 240;
   localparam int RSP_TDATA_W = 48;

   // command codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SMALL = 2'd2;

   typedef struct packed {
      logic [CAP_W-1:0]      buffer_capacity;
      logic [RAW_NAME_W-1:0] name_high;
      logic [RAW_NAME_W-1:0] name_low;
      logic [DATA_W-1:0]     event_cookie;
      logic [DATA_W-1:0]     event_mask;
      logic [DATA_W-1:0]     watch_id;
      logic                  opcode;
   } req_type;

   // one stored record
   typedef struct packed {
      logic [WCNT_W-1:0]    name_words;
      logic [NAME_BITS-1:0] name;
      logic [DATA_W-1:0]    event_cookie;
      logic [DATA_W-1:0]    event_mask;
      logic [DATA_W-1:0]    watch_id;
   } rec_type;

   // classified command
   typedef struct packed {
      logic             opcode;
      logic [CAP_W-1:0] capacity;
      rec_type          rec;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data_word;
      logic                last_word;
      logic [BYTES_W-1:0]  record_bytes;
      logic                overflow_seen;
      logic [PEND_W-1:0]   events_pending;
   } rsp_type;

endpackage

// ----- design/fser_ram.sv -----
// ----------------------------------------------------------------------------
// fser_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fser_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fser_front.sv -----
// ----------------------------------------------------------------------------
// fser_front: command intake
// accepts request words, cuts the name at its terminator and counts the
// name words that a later read will emit
// ----------------------------------------------------------------------------
module fser_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  fser_pkg::req_type req,
   input  logic              q_full,
   output logic              q_push,
   output fser_pkg::cmd_type q_entry
);
   import fser_pkg::*;

   logic [2*RAW_NAME_W-1:0] name_raw;
   logic [NAME_SLOTS-1:0]   keep;
   logic [NAME_BITS-1:0]    name_cut;
   logic [WCNT_W-1:0]       words;

   assign name_raw = {req.name_high, req.name_low};

   // keep[i]: byte i lies before the terminator and within the name limit
   always_comb begin
      logic run;
      run = 1'b1;
      for (int i = 0; i < NAME_SLOTS; i++) begin
         if (i < NAME_CHARS) begin
            run = run & (name_raw[8*i +: 8] != 8'h00);
         end else begin
            run = 1'b0;
         end
         keep[i]            = run;
         name_cut[8*i +: 8] = run ? name_raw[8*i +: 8] : 8'h00;
      end
   end

   // padded name words: one per four bytes of name plus terminator, none for an empty name
   always_comb begin
      words = '0;
      for (int k = 1; k <= NAME_WORDS_MAX; k++) begin
         words = words + WCNT_W'(keep[(k == 1) ? 0 : 4*k - 5]);
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_entry                  = '0;
      q_entry.opcode           = req.opcode;
      q_entry.capacity         = req.buffer_capacity;
      q_entry.rec.watch_id     = req.watch_id;
      q_entry.rec.event_mask   = req.event_mask;
      q_entry.rec.event_cookie = req.event_cookie;
      q_entry.rec.name         = name_cut;
      q_entry.rec.name_words   = words;
   end

endmodule

// ----- design/fser_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// fser_cmd_queue: short command queue
// decouples the intake from the serialiser so that each can stall alone
// ----------------------------------------------------------------------------
module fser_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fser_pkg::cmd_type push_entry,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output fser_pkg::cmd_type head_entry
);
   import fser_pkg::*;

   cmd_type                entries_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full       = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/fser_back.sv -----
// ----------------------------------------------------------------------------
// fser_back: record ring and serialiser
// executes commands in order: stores records, or reads the oldest one and
// sends it out one word at a time through an output register
// ----------------------------------------------------------------------------
module fser_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  fser_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fser_pkg::rsp_type rsp
);
   import fser_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   localparam logic [WIDX_W-1:0] W_ID     = WIDX_W'(0);
   localparam logic [WIDX_W-1:0] W_MASK   = WIDX_W'(1);
   localparam logic [WIDX_W-1:0] W_COOKIE = WIDX_W'(2);
   localparam logic [WIDX_W-1:0] W_LEN    = WIDX_W'(3);

   state_type          state_ff, state_in;
   logic [QIDX_W-1:0]  head_ff, head_in;
   logic [QIDX_W-1:0]  tail_ff, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [WIDX_W-1:0]  idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               ram_wr_en, ram_rd_en;
   logic [$bits(rec_type)-1:0] ram_rd_data;
   rec_type            rec;
   logic               out_free, push, ring_full;
   logic [DATA_W-1:0]  cur_word;
   logic [WIDX_W-1:0]  last_idx;
   logic [BYTES_W-1:0] total;
   logic               too_small;

   fser_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (cmd.rec),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign rec       = rec_type'(ram_rd_data);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ring_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign last_idx  = WIDX_W'(HDR_WORDS - 1) + WIDX_W'(rec.name_words);
   assign total     = BYTES_W'({(BYTES_W - 2)'(HDR_WORDS) + (BYTES_W - 2)'(rec.name_words),
                                2'b00});
   assign too_small = (cap_ff < CAP_W'(total));

   // word picked by the emit index
   always_comb begin
      cur_word = '0;
      case (idx_ff)
         W_ID:     cur_word = rec.watch_id;
         W_MASK:   cur_word = rec.event_mask;
         W_COOKIE: cur_word = rec.event_cookie;
         W_LEN:    cur_word = DATA_W'({rec.name_words, 2'b00});
         default: begin
            for (int k = 0; k < NAME_WORDS_MAX; k++) begin
               if (idx_ff == WIDX_W'(HDR_WORDS + k)) begin
                  cur_word = rec.name[32*k +: 32];
               end
            end
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      cap_in    = cap_ff;
      idx_in    = idx_ff;
      cmd_pop   = 1'b0;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      push      = 1'b0;
      rsp_in                = rsp_ff;
      rsp_in.overflow_seen  = ovf_ff;
      rsp_in.events_pending = PEND_W'(count_ff);
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.opcode == OP_ENQUEUE) begin
                  cmd_pop = 1'b1;
                  if (ring_full) begin
                     ovf_in = 1'b1;
                  end else begin
                     ram_wr_en = 1'b1;
                     tail_in   = (tail_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  if (out_free) begin
                     cmd_pop             = 1'b1;
                     push                = 1'b1;
                     rsp_in.status       = STAT_EMPTY;
                     rsp_in.data_word    = '0;
                     rsp_in.last_word    = 1'b1;
                     rsp_in.record_bytes = '0;
                  end
               end else begin
                  cmd_pop   = 1'b1;
                  ram_rd_en = 1'b1;
                  cap_in    = cmd.capacity;
                  state_in  = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               push                = 1'b1;
               rsp_in.record_bytes = total;
               if (too_small) begin
                  rsp_in.status    = STAT_SMALL;
                  rsp_in.data_word = '0;
                  rsp_in.last_word = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  rsp_in.status    = STAT_OK;
                  rsp_in.data_word = cur_word;
                  rsp_in.last_word = (idx_ff == last_idx);
                  // record leaves the ring with its first word
                  if (idx_ff == '0) begin
                     head_in  = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     count_in = count_ff - 1'b1;
                     rsp_in.events_pending = PEND_W'(count_ff - 1'b1);
                  end
                  if (idx_ff == last_idx) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output word held steady until it is taken
   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
      if (push) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // ring occupancy stays within its depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("ring occupancy beyond depth");

   // an empty ring has its pointers together
   a_empty_ptrs : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty ring with split pointers");

   // stores happen only between reads and never into a full ring
   a_store_when : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE) && !ring_full && !ram_rd_en)
      else $error("ring write outside idle or into full ring");

   // a fetch is always followed by serialising
   a_fetch_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_EMIT))
      else $error("fetch not followed by emit");

endmodule

// ----- design/fs_event_ring_serializer_top.sv -----
// ----------------------------------------------------------------------------
// fs_event_ring_serializer_top: file-change event ring with word serialiser
// queues event records and returns the oldest as little-endian 32-bit words
// ----------------------------------------------------------------------------
// Commands enter on req_; an enqueue (tuser 0) stores the record in a ring of
// QUEUE_DEPTH entries, or sets the sticky overflow flag when the ring is full,
// and gives no result. A read (tuser 1) returns the oldest record as id, mask,
// cookie, padded name length and zero-padded name words, tlast on the final
// word; an empty ring or a buffer capacity below the record size gives one
// word of status instead and consumes nothing. A two-entry command queue sits
// between the intake and the serialiser, so commands keep being taken while
// a read is sent. A read of a non-empty ring goes through a registered ring
// read (ST_FETCH) and then sends one word per cycle while the output register
// is free (one word when the buffer is too small, otherwise 4 to 8); the
// ring's single read port and the one-word output register shape this flow.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fs_event_ring_serializer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // watch_id, event_mask, event_cookie, name_low, name_high, buffer_capacity
   input  logic [fser_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // data_word, record_bytes, overflow_seen, events_pending, zero fill
   output logic [fser_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status
   output logic [fser_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                               rsp_tlast
);
   import fser_pkg::*;

   req_type req;
   cmd_type q_entry, head_entry;
   logic    q_push, q_full, head_valid, cmd_pop;
   rsp_type rsp;

   // unpack the request word, lowest field first
   assign req.opcode          = req_tuser[0];
   assign req.watch_id        = req_tdata[31:0];
   assign req.event_mask      = req_tdata[63:32];
   assign req.event_cookie    = req_tdata[95:64];
   assign req.name_low        = req_tdata[159:96];
   assign req.name_high       = req_tdata[223:160];
   assign req.buffer_capacity = req_tdata[239:224];

   fser_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req        (req),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // command queue lets intake and serialiser stall independently
   fser_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   fser_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_entry),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the result word, lowest field first
   assign rsp_tdata = {3'b000, rsp.events_pending, rsp.overflow_seen,
                       rsp.record_bytes, rsp.data_word};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last_word;

endmodule
